>>> sv/sncr_pkg.sv
// shared types and constants for the static nat checksum rewrite block
// no dependencies; used by the channel interfaces and the top level
package sncr_pkg;

   typedef logic [31:0] addr_type;
   typedef logic [15:0] word16_type;
   typedef logic [7:0]  byte_type;
   typedef logic [5:0]  flags_type;

   localparam byte_type PROTO_ICMP = 8'd1;
   localparam byte_type PROTO_TCP  = 8'd6;
   localparam byte_type PROTO_UDP  = 8'd17;

   localparam byte_type ICMP_UNREACHABLE    = 8'd3;
   localparam byte_type ICMP_TTL_EXPIRED    = 8'd11;
   localparam byte_type ICMP_PARAM_PROBLEM  = 8'd12;

   localparam int FLAG_FIRST = 0;
   localparam int FLAG_HW    = 1;
   localparam int FLAG_L4    = 2;
   localparam int FLAG_INNER = 3;
   localparam int FLAG_DNAT  = 4;
   localparam int FLAG_SNAT  = 5;

   localparam word16_type ALL_ONES16 = 16'hFFFF;

endpackage

>>> sv/sncr_req_if.sv
// request channel: one parsed ipv4 header summary per word
// depends on sncr_pkg
interface sncr_req_if import sncr_pkg::*; ();
   logic       valid;
   logic       ready;
   addr_type   old_source;
   addr_type   old_destination;
   addr_type   new_source;
   addr_type   new_destination;
   word16_type header_rest_sum;
   byte_type   protocol;
   flags_type  packet_flags;
   word16_type transport_checksum;
   byte_type   icmp_type;
   addr_type   inner_source;
   addr_type   inner_destination;

   modport source (
      output valid, old_source, old_destination, new_source, new_destination,
             header_rest_sum, protocol, packet_flags, transport_checksum,
             icmp_type, inner_source, inner_destination,
      input  ready
   );
   modport sink (
      input  valid, old_source, old_destination, new_source, new_destination,
             header_rest_sum, protocol, packet_flags, transport_checksum,
             icmp_type, inner_source, inner_destination,
      output ready
   );
endinterface

>>> sv/sncr_rsp_if.sv
// response channel: rewritten checksums and inner addresses per word
// depends on sncr_pkg
interface sncr_rsp_if import sncr_pkg::*; ();
   logic       valid;
   logic       ready;
   word16_type ip_checksum;
   word16_type new_transport_checksum;
   logic       transport_written;
   addr_type   new_inner_source;
   addr_type   new_inner_destination;
   logic       inner_updated;
   logic       status;

   modport source (
      output valid, ip_checksum, new_transport_checksum, transport_written,
             new_inner_source, new_inner_destination, inner_updated, status,
      input  ready
   );
   modport sink (
      input  valid, ip_checksum, new_transport_checksum, transport_written,
             new_inner_source, new_inner_destination, inner_updated, status,
      output ready
   );
endinterface

>>> sv/static_nat_checksum_rewrite_top.sv
// static nat checksum rewrite: three register stages, one word per cycle unless the response channel stalls
// an accepted request moves through the stage 1, 2 and 3 registers; stage 3 drives the response
// each stage loads when empty or when the next stage moves, so bubbles are squeezed out
// reset (synchronous, active high) clears the stage valid bits; payload is not reset
// depends on sncr_pkg, sncr_req_if, sncr_rsp_if
module static_nat_checksum_rewrite_top import sncr_pkg::*; (
   input logic          clock,
   input logic          reset,
   sncr_req_if.sink     req_chan,
   sncr_rsp_if.source   rsp_chan
);

   typedef struct packed {
      logic tcp_wr;
      logic hw;
      logic udp_wr;
      logic icmp_wr;
      logic status;
   } ctl_type;

   function automatic word16_type fold19(input logic [18:0] s);
      logic [16:0] t;
      logic [16:0] u;
      t = {1'b0, s[15:0]} + {14'd0, s[18:16]};
      u = {1'b0, t[15:0]} + {16'd0, t[16]};
      return u[15:0];
   endfunction

   function automatic word16_type oc_add16(input word16_type a, input word16_type b);
      logic [16:0] t;
      logic [16:0] u;
      t = {1'b0, a} + {1'b0, b};
      u = {1'b0, t[15:0]} + {16'd0, t[16]};
      return u[15:0];
   endfunction

   function automatic logic [18:0] sum8(input addr_type a, input addr_type b,
                                        input addr_type c, input addr_type d);
      return 19'(a[31:16]) + 19'(a[15:0]) + 19'(b[31:16]) + 19'(b[15:0])
           + 19'(c[31:16]) + 19'(c[15:0]) + 19'(d[31:16]) + 19'(d[15:0]);
   endfunction

   // stage enables
   logic en1, en2, en3;

   // stage 1
   logic        s1_valid_ff;
   logic [18:0] s1_ipsum_ff,  s1_ipsum_in;
   logic [18:0] s1_delta_ff,  s1_delta_in;
   word16_type  s1_csum_ff;
   ctl_type     s1_ctl_ff,    s1_ctl_in;
   addr_type    s1_is_ff, s1_id_ff, s1_nis_ff, s1_nis_in, s1_nid_ff, s1_nid_in;

   // stage 2
   logic        s2_valid_ff;
   word16_type  s2_ipc_ff,    s2_ipc_in;
   word16_type  s2_delta_ff,  s2_delta_in;
   logic [18:0] s2_inner_ff,  s2_inner_in;
   word16_type  s2_csum_ff;
   ctl_type     s2_ctl_ff;
   addr_type    s2_nis_ff, s2_nid_ff;

   // stage 3 (output)
   logic        s3_valid_ff;
   word16_type  s3_ipc_ff;
   word16_type  s3_tc_ff,     s3_tc_in;
   logic        s3_tw_ff;
   addr_type    s3_nis_ff, s3_nid_ff;
   logic        s3_upd_ff;
   logic        s3_status_ff;

   assign en3 = !s3_valid_ff || rsp_chan.ready;
   assign en2 = !s2_valid_ff || en3;
   assign en1 = !s1_valid_ff || en2;
   assign req_chan.ready = en1;

   // stage 1: decode, address compares, raw sums
   always_comb begin
      logic first, l4, inner, tcp, udp, icmp, icmp_err, inner_proc, dnat_hit, snat_hit;
      first      = req_chan.packet_flags[FLAG_FIRST];
      l4         = req_chan.packet_flags[FLAG_L4];
      inner      = req_chan.packet_flags[FLAG_INNER];
      tcp        = req_chan.protocol == PROTO_TCP;
      udp        = req_chan.protocol == PROTO_UDP;
      icmp       = req_chan.protocol == PROTO_ICMP;
      icmp_err   = req_chan.icmp_type inside {ICMP_UNREACHABLE, ICMP_TTL_EXPIRED,
                                              ICMP_PARAM_PROBLEM};
      inner_proc = first && icmp && icmp_err && inner;
      dnat_hit   = inner_proc && req_chan.packet_flags[FLAG_DNAT]
                   && (req_chan.inner_source == req_chan.old_destination);
      snat_hit   = inner_proc && req_chan.packet_flags[FLAG_SNAT]
                   && (req_chan.inner_destination == req_chan.old_source);

      s1_ipsum_in = 19'(req_chan.header_rest_sum)
                  + 19'(req_chan.new_source[31:16]) + 19'(req_chan.new_source[15:0])
                  + 19'(req_chan.new_destination[31:16])
                  + 19'(req_chan.new_destination[15:0]);
      s1_delta_in = sum8(~req_chan.old_source, ~req_chan.old_destination,
                         req_chan.new_source, req_chan.new_destination);

      s1_nis_in = !inner_proc ? '0 :
                  (dnat_hit ? req_chan.new_destination : req_chan.inner_source);
      s1_nid_in = !inner_proc ? '0 :
                  (snat_hit ? req_chan.new_source : req_chan.inner_destination);

      s1_ctl_in.tcp_wr  = first && tcp && l4;
      s1_ctl_in.hw      = req_chan.packet_flags[FLAG_HW];
      s1_ctl_in.udp_wr  = first && udp && l4 && (req_chan.transport_checksum != '0);
      s1_ctl_in.icmp_wr = dnat_hit || snat_hit;
      s1_ctl_in.status  = first && (((tcp || udp) && !l4) || (icmp && icmp_err && !inner));
   end

   // stage 2: fold ip and delta sums, raw inner sum
   always_comb begin
      s2_ipc_in   = ~fold19(s1_ipsum_ff);
      s2_delta_in = fold19(s1_delta_ff);
      s2_inner_in = sum8(~s1_is_ff, ~s1_id_ff, s1_nis_ff, s1_nid_ff);
   end

   // stage 3: final checksum adjust
   always_comb begin
      word16_type x;
      x = '0;
      s3_tc_in = '0;
      if (s2_ctl_ff.icmp_wr) begin
         s3_tc_in = ~oc_add16(fold19(s2_inner_ff), ~s2_csum_ff);
      end else if (s2_ctl_ff.tcp_wr) begin
         x = oc_add16(s2_delta_ff, s2_ctl_ff.hw ? s2_csum_ff : ~s2_csum_ff);
         s3_tc_in = s2_ctl_ff.hw ? x : ~x;
      end else if (s2_ctl_ff.udp_wr) begin
         x = ~oc_add16(s2_delta_ff, ~s2_csum_ff);
         s3_tc_in = (x == '0) ? ALL_ONES16 : x;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (en1) s1_valid_ff <= req_chan.valid;
         if (en2) s2_valid_ff <= s1_valid_ff;
         if (en3) s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_ipsum_ff <= s1_ipsum_in;
         s1_delta_ff <= s1_delta_in;
         s1_csum_ff  <= req_chan.transport_checksum;
         s1_ctl_ff   <= s1_ctl_in;
         s1_is_ff    <= req_chan.inner_source;
         s1_id_ff    <= req_chan.inner_destination;
         s1_nis_ff   <= s1_nis_in;
         s1_nid_ff   <= s1_nid_in;
      end
      if (en2) begin
         s2_ipc_ff   <= s2_ipc_in;
         s2_delta_ff <= s2_delta_in;
         s2_inner_ff <= s2_inner_in;
         s2_csum_ff  <= s1_csum_ff;
         s2_ctl_ff   <= s1_ctl_ff;
         s2_nis_ff   <= s1_nis_ff;
         s2_nid_ff   <= s1_nid_ff;
      end
      if (en3) begin
         s3_ipc_ff    <= s2_ipc_ff;
         s3_tc_ff     <= s3_tc_in;
         s3_tw_ff     <= s2_ctl_ff.tcp_wr || s2_ctl_ff.udp_wr || s2_ctl_ff.icmp_wr;
         s3_nis_ff    <= s2_nis_ff;
         s3_nid_ff    <= s2_nid_ff;
         s3_upd_ff    <= s2_ctl_ff.icmp_wr;
         s3_status_ff <= s2_ctl_ff.status;
      end
   end

   assign rsp_chan.valid                  = s3_valid_ff;
   assign rsp_chan.ip_checksum            = s3_ipc_ff;
   assign rsp_chan.new_transport_checksum = s3_tc_ff;
   assign rsp_chan.transport_written      = s3_tw_ff;
   assign rsp_chan.new_inner_source       = s3_nis_ff;
   assign rsp_chan.new_inner_destination  = s3_nid_ff;
   assign rsp_chan.inner_updated          = s3_upd_ff;
   assign rsp_chan.status                 = s3_status_ff;

   // back pressure only when every stage holds a word
   a_full_when_stalled: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (s1_valid_ff && s2_valid_ff && s3_valid_ff))
      else $error("input stalled with a free stage");

   a_unwritten_zero: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && !s3_tw_ff) |-> (s3_tc_ff == '0))
      else $error("checksum nonzero while not written");

   a_status_exclusive: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && s3_status_ff) |-> (!s3_tw_ff && !s3_upd_ff))
      else $error("error status with a rewrite");

   a_inner_implies_written: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && s3_upd_ff) |-> s3_tw_ff)
      else $error("inner rewrite without checksum write");

   a_one_hot_kind: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> $onehot0({s2_ctl_ff.tcp_wr, s2_ctl_ff.udp_wr, s2_ctl_ff.icmp_wr,
                                s2_ctl_ff.status}))
      else $error("conflicting transport kinds");

endmodule
